// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define APIQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define APIQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/apiq_pkg.sv =====
// ----------------------------------------------------------------------------
// apiq_pkg
// Types and constants shared by the AC presence input qualifier modules.
// ----------------------------------------------------------------------------
package apiq_pkg;

    localparam int IN_W  = 32;
    localparam int LINES = 3;

    localparam logic [7:0] CHECK_PERIOD_RST   = 8'd20;
    localparam logic [7:0] ON_CONFIRM_RST     = 8'd3;
    localparam logic [7:0] OFF_CONFIRM_RST    = 8'd3;
    localparam logic [3:0] SAMPLE_DIVIDER_RST = 4'd5;
    localparam logic [5:0] FILTER_WIDTH_RST   = 6'd32;
    localparam logic [4:0] LINE1_BIT_RST      = 5'd29;
    localparam logic [4:0] LINE2_BIT_RST      = 5'd30;
    localparam logic [4:0] LINE3_BIT_RST      = 5'd31;

    typedef enum logic [2:0] {
        REG_CHECK_PERIOD   = 3'd0,
        REG_ON_CONFIRM     = 3'd1,
        REG_OFF_CONFIRM    = 3'd2,
        REG_SAMPLE_DIVIDER = 3'd3,
        REG_FILTER_WIDTH   = 3'd4,
        REG_LINE1_BIT      = 3'd5,
        REG_LINE2_BIT      = 3'd6,
        REG_LINE3_BIT      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]             check_period;
        logic [7:0]             on_confirm;
        logic [7:0]             off_confirm;
        logic [3:0]             sample_divider;
        logic [5:0]             filter_width;
        logic [LINES-1:0][4:0]  line_bit;
    } cfg_t;

    typedef struct packed {
        logic set;
        logic clr;
    } line_evt_t;

endpackage

// ===== hdl/apiq_cfg.sv =====
// ----------------------------------------------------------------------------
// apiq_cfg
// APB register file holding the qualifier configuration.
// ----------------------------------------------------------------------------
module apiq_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output apiq_pkg::cfg_t      cfg
);

    apiq_pkg::cfg_t     cfg_reg;
    apiq_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = apiq_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_period   <= apiq_pkg::CHECK_PERIOD_RST;
            cfg_reg.on_confirm     <= apiq_pkg::ON_CONFIRM_RST;
            cfg_reg.off_confirm    <= apiq_pkg::OFF_CONFIRM_RST;
            cfg_reg.sample_divider <= apiq_pkg::SAMPLE_DIVIDER_RST;
            cfg_reg.filter_width   <= apiq_pkg::FILTER_WIDTH_RST;
            cfg_reg.line_bit[0]    <= apiq_pkg::LINE1_BIT_RST;
            cfg_reg.line_bit[1]    <= apiq_pkg::LINE2_BIT_RST;
            cfg_reg.line_bit[2]    <= apiq_pkg::LINE3_BIT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                apiq_pkg::REG_CHECK_PERIOD:   cfg_reg.check_period   <= pwdata[7:0];
                apiq_pkg::REG_ON_CONFIRM:     cfg_reg.on_confirm     <= pwdata[7:0];
                apiq_pkg::REG_OFF_CONFIRM:    cfg_reg.off_confirm    <= pwdata[7:0];
                apiq_pkg::REG_SAMPLE_DIVIDER: cfg_reg.sample_divider <= pwdata[3:0];
                apiq_pkg::REG_FILTER_WIDTH:   cfg_reg.filter_width   <= pwdata[5:0];
                apiq_pkg::REG_LINE1_BIT:      cfg_reg.line_bit[0]    <= pwdata[4:0];
                apiq_pkg::REG_LINE2_BIT:      cfg_reg.line_bit[1]    <= pwdata[4:0];
                apiq_pkg::REG_LINE3_BIT:      cfg_reg.line_bit[2]    <= pwdata[4:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            apiq_pkg::REG_CHECK_PERIOD:   prdata = {24'd0, cfg_reg.check_period};
            apiq_pkg::REG_ON_CONFIRM:     prdata = {24'd0, cfg_reg.on_confirm};
            apiq_pkg::REG_OFF_CONFIRM:    prdata = {24'd0, cfg_reg.off_confirm};
            apiq_pkg::REG_SAMPLE_DIVIDER: prdata = {28'd0, cfg_reg.sample_divider};
            apiq_pkg::REG_FILTER_WIDTH:   prdata = {26'd0, cfg_reg.filter_width};
            apiq_pkg::REG_LINE1_BIT:      prdata = {27'd0, cfg_reg.line_bit[0]};
            apiq_pkg::REG_LINE2_BIT:      prdata = {27'd0, cfg_reg.line_bit[1]};
            apiq_pkg::REG_LINE3_BIT:      prdata = {27'd0, cfg_reg.line_bit[2]};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/apiq_line.sv =====
// ----------------------------------------------------------------------------
// apiq_line
// Run and confirm counters and the present flag of one AC sense line.
// ----------------------------------------------------------------------------
module apiq_line
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  apiq_pkg::cfg_t          cfg,
    input  logic                    advance,
    input  logic                    level,
    output apiq_pkg::line_evt_t     evt,
    output logic                    present_next
);

    logic [7:0] high_run_reg, high_run_next;
    logic [7:0] low_run_reg, low_run_next;
    logic [7:0] on_count_reg, on_count_next;
    logic [7:0] off_count_reg, off_count_next;
    logic       present_reg;
    logic [7:0] high_inc, low_inc, on_inc, off_inc;

    assign high_inc = high_run_reg + 8'd1;
    assign low_inc  = low_run_reg + 8'd1;
    assign on_inc   = on_count_reg + 8'd1;
    assign off_inc  = off_count_reg + 8'd1;

    always_comb
    begin
        high_run_next  = high_run_reg;
        low_run_next   = low_run_reg;
        on_count_next  = on_count_reg;
        off_count_next = off_count_reg;
        evt            = '0;
        if (level)
        begin
            low_run_next = 8'd0;
            if (high_run_reg < cfg.check_period)
            begin
                high_run_next = high_inc;
                if (high_inc == cfg.check_period)
                begin
                    high_run_next  = 8'd0;
                    off_count_next = 8'd0;
                    if (on_count_reg < cfg.on_confirm)
                    begin
                        on_count_next = on_inc;
                        evt.set = (on_inc == cfg.on_confirm) & ~present_reg;
                    end
                end
            end
        end
        else
        begin
            high_run_next = 8'd0;
            if (low_run_reg < cfg.check_period)
            begin
                low_run_next = low_inc;
                if (low_inc == cfg.check_period)
                begin
                    low_run_next  = 8'd0;
                    on_count_next = 8'd0;
                    if (off_count_reg < cfg.off_confirm)
                    begin
                        off_count_next = off_inc;
                        evt.clr = (off_inc == cfg.off_confirm) & present_reg;
                    end
                end
            end
        end
        present_next = (present_reg | evt.set) & ~evt.clr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_run_reg  <= 8'd0;
            low_run_reg   <= 8'd0;
            on_count_reg  <= 8'd0;
            off_count_reg <= 8'd0;
            present_reg   <= 1'b0;
        end
        else if (advance)
        begin
            high_run_reg  <= high_run_next;
            low_run_reg   <= low_run_next;
            on_count_reg  <= on_count_next;
            off_count_reg <= off_count_next;
            present_reg   <= present_next;
        end
    end

endmodule

// ===== hdl/apiq_word.sv =====
// ----------------------------------------------------------------------------
// apiq_word
// Sample phase, three-deep sample history and the agreement filter that
// produces the qualified input word.
// ----------------------------------------------------------------------------
module apiq_word
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  apiq_pkg::cfg_t                              cfg,
    input  logic                                        advance,
    input  logic [apiq_pkg::IN_W-1:0]                   raw,
    input  apiq_pkg::line_evt_t [apiq_pkg::LINES-1:0]   evt,
    input  logic [apiq_pkg::LINES-1:0]                  present_next,
    output logic [apiq_pkg::IN_W-1:0]                   qual_next,
    output logic                                        sampled_next
);

    logic [apiq_pkg::IN_W-1:0] hist0_reg, hist1_reg, hist2_reg;
    logic [apiq_pkg::IN_W-1:0] hist0_next, hist1_next, hist2_next;
    logic [apiq_pkg::IN_W-1:0] qual_reg;
    logic [3:0]                phase_reg, phase_next, phase_inc;
    logic [apiq_pkg::IN_W-1:0] line_mask [apiq_pkg::LINES];
    logic [apiq_pkg::IN_W-1:0] present_word, width_mask, agree;

    always_comb
    begin
        present_word = '0;
        for (int i = 0; i < apiq_pkg::LINES; i++)
        begin
            line_mask[i] = apiq_pkg::IN_W'(1) << cfg.line_bit[i];
            if (present_next[i])
            begin
                present_word = present_word | line_mask[i];
            end
        end
        for (int j = 0; j < apiq_pkg::IN_W; j++)
        begin
            width_mask[j] = (cfg.filter_width > 6'(j));
        end
    end

    assign phase_inc    = phase_reg + 4'd1;
    assign phase_next   = (phase_inc == cfg.sample_divider) ? 4'd0 : phase_inc;
    assign sampled_next = (phase_next == 4'd0);

    always_comb
    begin
        qual_next  = qual_reg;
        hist0_next = hist0_reg;
        hist1_next = hist1_reg;
        hist2_next = hist2_reg;
        for (int i = 0; i < apiq_pkg::LINES; i++)
        begin
            if (evt[i].set)
            begin
                qual_next  = qual_next | line_mask[i];
                hist0_next = hist0_next | line_mask[i];
                hist1_next = hist1_next | line_mask[i];
            end
            else if (evt[i].clr)
            begin
                qual_next  = qual_next & ~line_mask[i];
                hist0_next = hist0_next & ~line_mask[i];
                hist1_next = hist1_next & ~line_mask[i];
            end
        end
        agree = '0;
        if (sampled_next)
        begin
            hist2_next = hist1_next;
            hist1_next = hist0_next;
            hist0_next = raw | present_word;
            agree      = ~((hist0_next ^ hist1_next) | (hist0_next ^ hist2_next)) & width_mask;
            qual_next  = (qual_next & ~agree) | (hist2_next & agree);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            qual_reg  <= '0;
            phase_reg <= 4'd0;
        end
        else if (advance)
        begin
            hist0_reg <= hist0_next;
            hist1_reg <= hist1_next;
            hist2_reg <= hist2_next;
            qual_reg  <= qual_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hdl/ac_presence_input_qualifier.sv =====
// ----------------------------------------------------------------------------
// ac_presence_input_qualifier
// AC line presence detector with a three-sample agreement filter on a
// 32-bit raw input word.
// ----------------------------------------------------------------------------
// Each slave beat is one tick carrying the three AC sense levels and the raw
// input word. Each tick produces exactly one master beat with the qualified
// word, the three present flags and a flag telling whether the filter
// sampled on that tick. Configuration is to be written through the APB port
// only while no tick is in flight; the block itself does not enforce this.
// A tick is held in an input register, then the counters, history and
// filter update in one pass and the result lands in the output register.
// Throughput is one tick per cycle unless the receiver stalls; the state
// update of a tick completes in the same cycle its result is registered.
// When the receiver stalls, the output register holds its beat and the
// input register takes one more tick; the slave side then deasserts tready.
// Reset clears all counters, flags, history, the qualified word and the
// sample phase, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module ac_presence_input_qualifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // ac_levels[2:0], raw_inputs[34:3], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // qualified_inputs[31:0], ac_present[34:32],
                                        // sampled[35], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    apiq_pkg::cfg_t                             cfg;
    apiq_pkg::line_evt_t [apiq_pkg::LINES-1:0]  evt;
    logic [apiq_pkg::LINES-1:0]                 present_next;
    logic [apiq_pkg::IN_W-1:0]                  qual_next;
    logic                                       sampled_next;

    logic                           in_valid_reg;
    logic [apiq_pkg::LINES-1:0]     in_levels_reg;
    logic [apiq_pkg::IN_W-1:0]      in_raw_reg;
    logic                           out_valid_reg;
    logic [apiq_pkg::IN_W-1:0]      out_qual_reg;
    logic [apiq_pkg::LINES-1:0]     out_present_reg;
    logic                           out_sampled_reg;
    logic                           advance;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_sampled_reg, out_present_reg, out_qual_reg};

    apiq_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar i = 0; i < apiq_pkg::LINES; i++)
    begin : g_line
        apiq_line u_line
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg          (cfg),
            .advance      (advance),
            .level        (in_levels_reg[i]),
            .evt          (evt[i]),
            .present_next (present_next[i])
        );
    end

    apiq_word u_word
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .advance      (advance),
        .raw          (in_raw_reg),
        .evt          (evt),
        .present_next (present_next),
        .qual_next    (qual_next),
        .sampled_next (sampled_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready & s_axis_tvalid)
        begin
            in_levels_reg <= s_axis_tdata[2:0];
            in_raw_reg    <= s_axis_tdata[34:3];
        end
        if (advance)
        begin
            out_qual_reg    <= qual_next;
            out_present_reg <= present_next;
            out_sampled_reg <= sampled_next;
        end
    end

endmodule

// ===== hdl/apiq_checker.sv =====
// ----------------------------------------------------------------------------
// apiq_checker
// Port-level checks of the AC presence input qualifier, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apiq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);

    // The slave side stalls only behind a waiting master beat.
    `APIQ_ASSERT_SAME(a_stall_needs_output, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `APIQ_ASSERT_SAME(a_empty_output_ready, !m_axis_tvalid, s_axis_tready)
    `APIQ_ASSERT_NEXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `APIQ_ASSERT_NEXT(a_out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `APIQ_ASSERT_SAME(a_pad_zero, m_axis_tvalid && pready, m_axis_tdata[39:36] == 4'd0)

endmodule

bind ac_presence_input_qualifier apiq_checker u_apiq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
